// ===== src/rcrs_pkg.sv =====
// package for the ray circle range scan: constants, register indexes, pipeline types, helpers
package rcrs_pkg;

    localparam int MAX_BEAMS  = 1024;
    localparam int ITERATIONS = 16;
    localparam int SQ_W       = 56;
    localparam int SQ_STEPS   = SQ_W / 2;

    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic [23:0]        RANGE_GAP    = 24'd6554;
    localparam logic [22:0]        RADIUS_FLOOR = 23'd3277;
    localparam logic [15:0]        STEP_FLOOR   = 16'd9;

    localparam logic signed [31:0] ATAN_TURN [24] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    localparam int ST_ANGLE = 0;
    localparam int ST_POST  = ITERATIONS + 1;
    localparam int ST_MUL1  = ITERATIONS + 2;
    localparam int ST_MUL2  = ITERATIONS + 3;
    localparam int ST_MUL3  = ITERATIONS + 4;
    localparam int ST_DISC  = ITERATIONS + 5;
    localparam int ST_SQRT  = ITERATIONS + 6;
    localparam int ST_SEL   = ST_SQRT + SQ_STEPS;
    localparam int ST_POINT = ST_SEL + 1;
    localparam int ST_OUT   = ST_SEL + 2;
    localparam int NUM_ST   = ST_OUT + 1;

    localparam logic [2:0] REG_CIRCLE_X    = 3'd0;
    localparam logic [2:0] REG_CIRCLE_Y    = 3'd1;
    localparam logic [2:0] REG_RADIUS      = 3'd2;
    localparam logic [2:0] REG_MIN_RANGE   = 3'd3;
    localparam logic [2:0] REG_MAX_RANGE   = 3'd4;
    localparam logic [2:0] REG_START_ANGLE = 3'd5;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd6;
    localparam logic [2:0] REG_MOUNT_YAW   = 3'd7;

    typedef struct packed {
        logic                valid;
        logic [9:0]          idx;
        logic                beam_ok;
        logic signed [23:0]  px;
        logic signed [23:0]  py;
        logic [1:0]          wq;
        logic [1:0]          bq;
        logic signed [33:0]  wx;
        logic signed [33:0]  wy;
        logic signed [31:0]  wz;
        logic signed [33:0]  bx;
        logic signed [33:0]  by;
        logic signed [31:0]  bz;
        logic signed [17:0]  wc;
        logic signed [17:0]  ws;
        logic signed [17:0]  bc;
        logic signed [17:0]  bs;
        logic signed [24:0]  fx;
        logic signed [24:0]  fy;
        logic signed [42:0]  pa;
        logic signed [42:0]  pb;
        logic signed [49:0]  qa;
        logic signed [49:0]  qb;
        logic [45:0]         rr;
        logic signed [27:0]  h;
        logic signed [51:0]  c;
        logic signed [55:0]  hh;
        logic                neg;
        logic [SQ_W-1:0]     rem;
        logic [SQ_W-1:0]     res;
        logic                hit;
        logic [23:0]         t;
        logic signed [42:0]  ox;
        logic signed [42:0]  oy;
        logic signed [23:0]  ptx;
        logic signed [23:0]  pty;
    } pipe_t;

    // round half up from q30 to q16, clamp to one
    function automatic logic signed [17:0] unit_round(input logic signed [33:0] v);
        logic signed [34:0] r;
        r = (35'(v) + 35'sd8192) >>> 14;
        if (r > 35'sd65536) begin
            return 18'sd65536;
        end else if (r < -35'sd65536) begin
            return -18'sd65536;
        end
        return 18'(r);
    endfunction

    // round half up by 16 bits, saturate to 24 bit signed
    function automatic logic signed [23:0] point_round(input logic signed [42:0] v);
        logic signed [43:0] r;
        r = (44'(v) + 44'sd32768) >>> 16;
        if (r > 44'sd8388607) begin
            return 24'sd8388607;
        end else if (r < -44'sd8388608) begin
            return -24'sd8388608;
        end
        return 24'(r);
    endfunction

endpackage

// ===== src/ray_circle_range_scan.sv =====
// ray circle range scan: one beam of a 2d range finder against one circle, deep pipeline
//
// requests on the s_ channel carry a sensor pose (x, y, yaw) and a beam index.
// each request yields exactly one result on the m_ channel, in order: the beam
// number, a hit flag, the range to the nearest positive crossing of the circle
// and the hit point in the sensor frame; a miss returns zeros.
// circle, range gate and beam geometry are set through the apb port, register
// i at byte address 4*i; write them only while no request is in flight.
// the pipe runs from acceptance to result valid through one angle stage,
// 16 cordic stages (one rotation each, both angles side by side), one
// quadrant stage, four multiply and discriminant stages, 28 square root
// stages (one root bit each), the root select, the point multiply and the
// output register. one request per cycle is taken while the pipe moves.
// when m_ready is low with a result waiting, the whole pipe holds and
// s_ready drops; nothing is lost or repeated.
// reset (synchronous, aresetn low) empties the pipe and loads register defaults.
module ray_circle_range_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [23:0]  s_pose_x,
    input  logic signed [23:0]  s_pose_y,
    input  logic [15:0]         s_pose_yaw,
    input  logic [9:0]          s_beam_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [9:0]          m_beam_number,
    output logic                m_hit,
    output logic [22:0]         m_range,
    output logic signed [23:0]  m_point_x,
    output logic signed [23:0]  m_point_y
);
    import rcrs_pkg::*;

    logic signed [23:0] circle_x_reg;
    logic signed [23:0] circle_y_reg;
    logic [22:0]        radius_reg;
    logic [22:0]        min_range_reg;
    logic [22:0]        max_range_reg;
    logic [15:0]        start_angle_reg;
    logic [15:0]        angle_step_reg;
    logic [15:0]        mount_yaw_reg;

    logic        wr_en;
    logic [2:0]  wr_idx;
    logic [22:0] radius_eff;
    logic [15:0] step_eff;
    logic [23:0] rmax_eff;
    logic        en;

    pipe_t st_reg  [NUM_ST];
    pipe_t st_next [NUM_ST];

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            circle_x_reg    <= '0;
            circle_y_reg    <= '0;
            radius_reg      <= 23'd42598;
            min_range_reg   <= 23'd13107;
            max_range_reg   <= 23'd229376;
            start_angle_reg <= 16'd32768;
            angle_step_reg  <= 16'd91;
            mount_yaw_reg   <= 16'd49152;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_CIRCLE_X:    circle_x_reg    <= pwdata[23:0];
                REG_CIRCLE_Y:    circle_y_reg    <= pwdata[23:0];
                REG_RADIUS:      radius_reg      <= pwdata[22:0];
                REG_MIN_RANGE:   min_range_reg   <= pwdata[22:0];
                REG_MAX_RANGE:   max_range_reg   <= pwdata[22:0];
                REG_START_ANGLE: start_angle_reg <= pwdata[15:0];
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata[15:0];
                REG_MOUNT_YAW:   mount_yaw_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_CIRCLE_X:    prdata = {8'd0, circle_x_reg};
            REG_CIRCLE_Y:    prdata = {8'd0, circle_y_reg};
            REG_RADIUS:      prdata = {9'd0, radius_reg};
            REG_MIN_RANGE:   prdata = {9'd0, min_range_reg};
            REG_MAX_RANGE:   prdata = {9'd0, max_range_reg};
            REG_START_ANGLE: prdata = {16'd0, start_angle_reg};
            REG_ANGLE_STEP:  prdata = {16'd0, angle_step_reg};
            REG_MOUNT_YAW:   prdata = {16'd0, mount_yaw_reg};
            default:         prdata = '0;
        endcase
    end

    assign radius_eff = (radius_reg < RADIUS_FLOOR) ? RADIUS_FLOOR : radius_reg;
    assign step_eff   = (angle_step_reg < STEP_FLOOR) ? STEP_FLOOR : angle_step_reg;

    always_comb begin
        logic [23:0] gap_min;
        gap_min  = 24'(min_range_reg) + RANGE_GAP;
        rmax_eff = (24'(max_range_reg) < gap_min) ? gap_min : 24'(max_range_reg);
    end

    // whole pipe advances unless a result waits with m_ready low
    assign en      = !st_reg[ST_OUT].valid || m_ready;
    assign s_ready = en;

    // beam angles and cordic seeds
    always_comb begin
        logic [25:0] prod;
        logic [15:0] base;
        logic [15:0] world;
        st_next[ST_ANGLE]         = st_reg[ST_ANGLE];
        prod                      = 26'(s_beam_index) * 26'(step_eff);
        base                      = start_angle_reg + prod[15:0];
        world                     = s_pose_yaw + mount_yaw_reg + base;
        st_next[ST_ANGLE].valid   = s_valid;
        st_next[ST_ANGLE].idx     = s_beam_index;
        st_next[ST_ANGLE].beam_ok = 32'(s_beam_index) < MAX_BEAMS;
        st_next[ST_ANGLE].px      = s_pose_x;
        st_next[ST_ANGLE].py      = s_pose_y;
        st_next[ST_ANGLE].wq      = world[15:14];
        st_next[ST_ANGLE].bq      = base[15:14];
        st_next[ST_ANGLE].wx      = CORDIC_GAIN;
        st_next[ST_ANGLE].wy      = '0;
        st_next[ST_ANGLE].wz      = {2'b00, world[13:0], 16'd0};
        st_next[ST_ANGLE].bx      = CORDIC_GAIN;
        st_next[ST_ANGLE].by      = '0;
        st_next[ST_ANGLE].bz      = {2'b00, base[13:0], 16'd0};
    end

    // cordic rotations, one per stage
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_cordic
        always_comb begin
            pipe_t n;
            n = st_reg[i];
            if (n.wz >= 0) begin
                n.wx = st_reg[i].wx - (st_reg[i].wy >>> i);
                n.wy = st_reg[i].wy + (st_reg[i].wx >>> i);
                n.wz = st_reg[i].wz - ATAN_TURN[i];
            end else begin
                n.wx = st_reg[i].wx + (st_reg[i].wy >>> i);
                n.wy = st_reg[i].wy - (st_reg[i].wx >>> i);
                n.wz = st_reg[i].wz + ATAN_TURN[i];
            end
            if (n.bz >= 0) begin
                n.bx = st_reg[i].bx - (st_reg[i].by >>> i);
                n.by = st_reg[i].by + (st_reg[i].bx >>> i);
                n.bz = st_reg[i].bz - ATAN_TURN[i];
            end else begin
                n.bx = st_reg[i].bx + (st_reg[i].by >>> i);
                n.by = st_reg[i].by - (st_reg[i].bx >>> i);
                n.bz = st_reg[i].bz + ATAN_TURN[i];
            end
            st_next[i + 1] = n;
        end
    end

    // quadrant fold, rounding, offsets to circle centre
    always_comb begin
        pipe_t n;
        n = st_reg[ST_POST - 1];
        unique case (n.wq)
            2'd0: begin n.wc = unit_round(n.wx);  n.ws = unit_round(n.wy);  end
            2'd1: begin n.wc = unit_round(-n.wy); n.ws = unit_round(n.wx);  end
            2'd2: begin n.wc = unit_round(-n.wx); n.ws = unit_round(-n.wy); end
            default: begin n.wc = unit_round(n.wy); n.ws = unit_round(-n.wx); end
        endcase
        unique case (n.bq)
            2'd0: begin n.bc = unit_round(n.bx);  n.bs = unit_round(n.by);  end
            2'd1: begin n.bc = unit_round(-n.by); n.bs = unit_round(n.bx);  end
            2'd2: begin n.bc = unit_round(-n.bx); n.bs = unit_round(-n.by); end
            default: begin n.bc = unit_round(n.by); n.bs = unit_round(-n.bx); end
        endcase
        n.fx = 25'(n.px) - 25'(circle_x_reg);
        n.fy = 25'(n.py) - 25'(circle_y_reg);
        st_next[ST_POST] = n;
    end

    // products
    always_comb begin
        pipe_t n;
        n    = st_reg[ST_MUL1 - 1];
        n.pa = 43'(n.fx) * 43'(n.wc);
        n.pb = 43'(n.fy) * 43'(n.ws);
        n.qa = 50'(n.fx) * 50'(n.fx);
        n.qb = 50'(n.fy) * 50'(n.fy);
        n.rr = 46'(radius_eff) * 46'(radius_eff);
        st_next[ST_MUL1] = n;
    end

    // half b and c of the quadratic
    always_comb begin
        pipe_t n;
        logic signed [43:0] sum;
        n   = st_reg[ST_MUL2 - 1];
        sum = 44'(n.pa) + 44'(n.pb);
        n.h = 28'((sum + 44'sd32768) >>> 16);
        n.c = 52'(n.qa) + 52'(n.qb) - 52'(n.rr);
        st_next[ST_MUL2] = n;
    end

    always_comb begin
        pipe_t n;
        n    = st_reg[ST_MUL3 - 1];
        n.hh = 56'(n.h) * 56'(n.h);
        st_next[ST_MUL3] = n;
    end

    // discriminant
    always_comb begin
        pipe_t n;
        logic signed [57:0] dd;
        n     = st_reg[ST_DISC - 1];
        dd    = 58'(n.hh) - 58'(n.c);
        n.neg = dd < 0;
        n.rem = dd[SQ_W-1:0];
        n.res = '0;
        st_next[ST_DISC] = n;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        always_comb begin
            pipe_t n;
            logic [SQ_W-1:0] bit_k;
            logic [SQ_W-1:0] trial;
            n     = st_reg[ST_SQRT + k - 1];
            bit_k = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            trial = n.res + bit_k;
            if (n.rem >= trial) begin
                n.rem = n.rem - trial;
                n.res = (n.res >> 1) + bit_k;
            end else begin
                n.res = n.res >> 1;
            end
            st_next[ST_SQRT + k] = n;
        end
    end

    // nearest positive root and range gate
    always_comb begin
        pipe_t n;
        logic signed [29:0] s;
        logic signed [29:0] t1;
        logic signed [29:0] t2;
        logic signed [29:0] tt;
        logic               pos;
        n   = st_reg[ST_SEL - 1];
        s   = 30'(n.res[SQ_STEPS:0]);
        t1  = -30'(n.h) - s;
        t2  = -30'(n.h) + s;
        pos = 1'b1;
        priority if (t1 > 0) begin
            tt = t1;
        end else if (t2 > 0) begin
            tt = t2;
        end else begin
            tt  = '0;
            pos = 1'b0;
        end
        n.hit = n.beam_ok && !n.neg && pos
                && (tt >= 30'(min_range_reg)) && (tt <= 30'(rmax_eff));
        n.t   = tt[23:0];
        st_next[ST_SEL] = n;
    end

    // hit point in sensor frame
    always_comb begin
        pipe_t n;
        n    = st_reg[ST_POINT - 1];
        n.ox = 43'(signed'({1'b0, n.t})) * 43'(n.bc);
        n.oy = 43'(signed'({1'b0, n.t})) * 43'(n.bs);
        st_next[ST_POINT] = n;
    end

    always_comb begin
        pipe_t n;
        n = st_reg[ST_OUT - 1];
        if (n.hit) begin
            n.ptx = point_round(n.ox);
            n.pty = point_round(n.oy);
        end else begin
            n.ptx = '0;
            n.pty = '0;
            n.t   = '0;
        end
        st_next[ST_OUT] = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_ST; j++) begin
                st_reg[j].valid <= 1'b0;
            end
        end else if (en) begin
            st_reg <= st_next;
        end
    end

    assign m_valid       = st_reg[ST_OUT].valid;
    assign m_beam_number = st_reg[ST_OUT].idx;
    assign m_hit         = st_reg[ST_OUT].hit;
    assign m_range       = st_reg[ST_OUT].t[22:0];
    assign m_point_x     = st_reg[ST_OUT].ptx;
    assign m_point_y     = st_reg[ST_OUT].pty;

endmodule
